// File: hdl/rdps_pkg.sv
// Shared types, constants and command codes for the remote drive pattern sequencer.
// Used by rdps_regs, rdps_core and remote_drive_pattern_sequencer; depends on nothing.
package rdps_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 10;
    localparam int THRESH_BITS   = 10;
    localparam int PERIOD_BITS   = 16;
    localparam int DUTY_BITS     = 8;
    localparam int DIR_BITS      = 2;
    localparam int STEP_BITS     = 3;
    localparam int TIME_BITS     = 32;
    localparam int BYTE_BITS     = 8;
    localparam int CMP_BITS      = 16;

    // Pattern lengths
    localparam int PATTERN_STEPS = 6;
    localparam int SHUTTLE_STEPS = 3;

    // Configuration port
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    typedef logic [CMP_BITS-1:0]  t_cmp;
    typedef logic [STEP_BITS:0]   t_step_ext;
    typedef logic [TIME_BITS-1:0] t_time;

    localparam t_step_ext PATTERN_LIMIT = t_step_ext'(PATTERN_STEPS);
    localparam t_step_ext SHUTTLE_LIMIT = t_step_ext'(SHUTTLE_STEPS);

    // Register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_FLOOR_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PATTERN_PERIOD  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SHUTTLE_PERIOD  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_STRAIGHT_DUTY   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_TURN_DUTY       = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_BOOST_DUTY      = 3'd5;

    // Register reset values
    localparam logic [THRESH_BITS-1:0] RST_FLOOR_THRESHOLD = 10'd300;
    localparam logic [PERIOD_BITS-1:0] RST_PATTERN_PERIOD  = 16'd2000;
    localparam logic [PERIOD_BITS-1:0] RST_SHUTTLE_PERIOD  = 16'd3000;
    localparam logic [DUTY_BITS-1:0]   RST_STRAIGHT_DUTY   = 8'd100;
    localparam logic [DUTY_BITS-1:0]   RST_TURN_DUTY       = 8'd160;
    localparam logic [DUTY_BITS-1:0]   RST_BOOST_DUTY      = 8'd180;

    // ASCII command codes
    localparam logic [BYTE_BITS-1:0] CMD_NONE       = 8'h00;
    localparam logic [BYTE_BITS-1:0] CMD_FWD_GUARD  = 8'h46; // F
    localparam logic [BYTE_BITS-1:0] CMD_FWD        = 8'h66; // f
    localparam logic [BYTE_BITS-1:0] CMD_BACK_GUARD = 8'h42; // B
    localparam logic [BYTE_BITS-1:0] CMD_BACK       = 8'h62; // b
    localparam logic [BYTE_BITS-1:0] CMD_RIGHT      = 8'h52; // R
    localparam logic [BYTE_BITS-1:0] CMD_LEFT       = 8'h4C; // L
    localparam logic [BYTE_BITS-1:0] CMD_STOP       = 8'h53; // S
    localparam logic [BYTE_BITS-1:0] CMD_SUCK_ON    = 8'h54; // T
    localparam logic [BYTE_BITS-1:0] CMD_SUCK_OFF   = 8'h50; // P
    localparam logic [BYTE_BITS-1:0] CMD_PATTERN_I  = 8'h49; // I
    localparam logic [BYTE_BITS-1:0] CMD_PATTERN_U  = 8'h55; // U
    localparam logic [BYTE_BITS-1:0] CMD_PATTERN_K  = 8'h4B; // K

    // Motor direction codes
    localparam logic [DIR_BITS-1:0] DIR_OFF    = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_FIRST  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_SECOND = 2'd2;

    // Wheel manoeuvres
    localparam int MOVE_BITS = 3;
    localparam logic [MOVE_BITS-1:0] MOVE_STOP  = 3'd0;
    localparam logic [MOVE_BITS-1:0] MOVE_FWD   = 3'd1;
    localparam logic [MOVE_BITS-1:0] MOVE_BACK  = 3'd2;
    localparam logic [MOVE_BITS-1:0] MOVE_RIGHT = 3'd3;
    localparam logic [MOVE_BITS-1:0] MOVE_LEFT  = 3'd4;

    typedef struct packed {
        logic [THRESH_BITS-1:0] floor_threshold;
        logic [PERIOD_BITS-1:0] pattern_period;
        logic [PERIOD_BITS-1:0] shuttle_period;
        logic [DUTY_BITS-1:0]   straight_duty;
        logic [DUTY_BITS-1:0]   turn_duty;
        logic [DUTY_BITS-1:0]   boost_duty;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] front_sample;
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic [SAMPLE_BITS-1:0] rear_sample;
        logic                   manual_switch;
        logic                   byte_valid;
        logic [BYTE_BITS-1:0]   rx_byte;
        logic [TIME_BITS-1:0]   now_ms;
    } t_item;

    typedef struct packed {
        logic [DIR_BITS-1:0]  motor_a_dir;
        logic [DUTY_BITS-1:0] motor_a_duty;
        logic [DIR_BITS-1:0]  motor_b_dir;
        logic [DUTY_BITS-1:0] motor_b_duty;
        logic [DIR_BITS-1:0]  motor_c_dir;
        logic [DUTY_BITS-1:0] motor_c_duty;
        logic [DIR_BITS-1:0]  motor_d_dir;
        logic [DUTY_BITS-1:0] motor_d_duty;
        logic                 suction_on;
        logic [STEP_BITS-1:0] pattern_step;
    } t_result;

endpackage

// File: hdl/rdps_regs.sv
// Configuration register bank with an APB-style write and read port.
// Depends on rdps_pkg for register indexes, reset values and the t_cfg type.
module rdps_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rdps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [rdps_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [rdps_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output rdps_pkg::t_cfg                      o_cfg
);

    rdps_pkg::t_cfg                       r_cfg;
    logic                                 w_write;
    logic [rdps_pkg::REG_IDX_BITS-1:0]    w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[rdps_pkg::CFG_ADDR_BITS-1:2];
    assign o_cfg   = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_threshold <= rdps_pkg::RST_FLOOR_THRESHOLD;
            r_cfg.pattern_period  <= rdps_pkg::RST_PATTERN_PERIOD;
            r_cfg.shuttle_period  <= rdps_pkg::RST_SHUTTLE_PERIOD;
            r_cfg.straight_duty   <= rdps_pkg::RST_STRAIGHT_DUTY;
            r_cfg.turn_duty       <= rdps_pkg::RST_TURN_DUTY;
            r_cfg.boost_duty      <= rdps_pkg::RST_BOOST_DUTY;
        end else if (w_write) begin
            case (w_index)
                rdps_pkg::REG_FLOOR_THRESHOLD: begin
                    r_cfg.floor_threshold <= pwdata[rdps_pkg::THRESH_BITS-1:0];
                end
                rdps_pkg::REG_PATTERN_PERIOD: begin
                    r_cfg.pattern_period <= pwdata[rdps_pkg::PERIOD_BITS-1:0];
                end
                rdps_pkg::REG_SHUTTLE_PERIOD: begin
                    r_cfg.shuttle_period <= pwdata[rdps_pkg::PERIOD_BITS-1:0];
                end
                rdps_pkg::REG_STRAIGHT_DUTY: begin
                    r_cfg.straight_duty <= pwdata[rdps_pkg::DUTY_BITS-1:0];
                end
                rdps_pkg::REG_TURN_DUTY: begin
                    r_cfg.turn_duty <= pwdata[rdps_pkg::DUTY_BITS-1:0];
                end
                rdps_pkg::REG_BOOST_DUTY: begin
                    r_cfg.boost_duty <= pwdata[rdps_pkg::DUTY_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data, zero extended; unused addresses read as zero.
    always_comb begin
        prdata = '0;
        case (w_index)
            rdps_pkg::REG_FLOOR_THRESHOLD: begin
                prdata = rdps_pkg::CFG_DATA_BITS'(r_cfg.floor_threshold);
            end
            rdps_pkg::REG_PATTERN_PERIOD: begin
                prdata = rdps_pkg::CFG_DATA_BITS'(r_cfg.pattern_period);
            end
            rdps_pkg::REG_SHUTTLE_PERIOD: begin
                prdata = rdps_pkg::CFG_DATA_BITS'(r_cfg.shuttle_period);
            end
            rdps_pkg::REG_STRAIGHT_DUTY: begin
                prdata = rdps_pkg::CFG_DATA_BITS'(r_cfg.straight_duty);
            end
            rdps_pkg::REG_TURN_DUTY: begin
                prdata = rdps_pkg::CFG_DATA_BITS'(r_cfg.turn_duty);
            end
            rdps_pkg::REG_BOOST_DUTY: begin
                prdata = rdps_pkg::CFG_DATA_BITS'(r_cfg.boost_duty);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// File: hdl/rdps_core.sv
// Command decode, pattern timing and motor drive logic with the sequencer state.
// Depends on rdps_pkg for command codes, direction codes and the shared structs.
module rdps_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rdps_pkg::t_item    i_item,
    input  rdps_pkg::t_cfg     i_cfg,
    output rdps_pkg::t_result  o_result
);

    logic [rdps_pkg::BYTE_BITS-1:0]  r_held_command, n_held_command;
    logic [rdps_pkg::STEP_BITS-1:0]  r_step_index, n_step_index;
    rdps_pkg::t_time                 r_step_start, n_step_start;
    logic                            r_suction, n_suction;

    logic                            w_front, w_left, w_right, w_rear;
    logic                            w_shuttle;
    logic [rdps_pkg::PERIOD_BITS-1:0] w_period;
    rdps_pkg::t_step_ext             w_limit;
    rdps_pkg::t_step_ext             w_incr;
    rdps_pkg::t_time                 w_elapsed;
    logic                            w_due;
    logic [rdps_pkg::STEP_BITS-1:0]  w_step_adv;
    logic [rdps_pkg::MOVE_BITS-1:0]  w_move;
    logic                            w_ok;

    // Floor presence: a sample below the threshold means floor underneath.
    assign w_front = rdps_pkg::t_cmp'(i_item.front_sample)
                   < rdps_pkg::t_cmp'(i_cfg.floor_threshold);
    assign w_left  = rdps_pkg::t_cmp'(i_item.left_sample)
                   < rdps_pkg::t_cmp'(i_cfg.floor_threshold);
    assign w_right = rdps_pkg::t_cmp'(i_item.right_sample)
                   < rdps_pkg::t_cmp'(i_cfg.floor_threshold);
    assign w_rear  = rdps_pkg::t_cmp'(i_item.rear_sample)
                   < rdps_pkg::t_cmp'(i_cfg.floor_threshold);

    // Latch a new command byte only in remote mode.
    assign n_held_command = (i_item.byte_valid && !i_item.manual_switch)
                          ? i_item.rx_byte : r_held_command;

    // Step timer: wrapping elapsed time against the period of the pattern in use.
    assign w_shuttle  = (n_held_command == rdps_pkg::CMD_PATTERN_K);
    assign w_period   = w_shuttle ? i_cfg.shuttle_period : i_cfg.pattern_period;
    assign w_limit    = w_shuttle ? rdps_pkg::SHUTTLE_LIMIT : rdps_pkg::PATTERN_LIMIT;
    assign w_elapsed  = i_item.now_ms - r_step_start;
    assign w_due      = w_elapsed >= rdps_pkg::t_time'(w_period);
    assign w_incr     = rdps_pkg::t_step_ext'(r_step_index) + rdps_pkg::t_step_ext'(1);
    assign w_step_adv = !w_due ? r_step_index
                      : (w_incr >= w_limit) ? '0
                      : w_incr[rdps_pkg::STEP_BITS-1:0];

    // Command decode into a wheel manoeuvre and the next state.
    always_comb begin
        n_step_index = r_step_index;
        n_step_start = r_step_start;
        n_suction    = r_suction;
        w_move       = rdps_pkg::MOVE_STOP;
        w_ok         = 1'b0;
        if (i_item.manual_switch) begin
            n_step_index = '0;
            n_step_start = i_item.now_ms;
        end else begin
            case (n_held_command)
                rdps_pkg::CMD_FWD_GUARD: begin
                    if (w_front) w_move = rdps_pkg::MOVE_FWD;
                end
                rdps_pkg::CMD_FWD: begin
                    w_move = rdps_pkg::MOVE_FWD;
                end
                rdps_pkg::CMD_BACK_GUARD: begin
                    if (w_rear) w_move = rdps_pkg::MOVE_BACK;
                end
                rdps_pkg::CMD_BACK: begin
                    w_move = rdps_pkg::MOVE_BACK;
                end
                rdps_pkg::CMD_RIGHT: begin
                    w_move = rdps_pkg::MOVE_RIGHT;
                end
                rdps_pkg::CMD_LEFT: begin
                    w_move = rdps_pkg::MOVE_LEFT;
                end
                rdps_pkg::CMD_STOP, rdps_pkg::CMD_SUCK_OFF: begin
                    n_suction = 1'b0;
                end
                rdps_pkg::CMD_SUCK_ON: begin
                    n_suction = 1'b1;
                end
                rdps_pkg::CMD_PATTERN_I: begin
                    if (w_due) n_step_start = i_item.now_ms;
                    n_step_index = w_step_adv;
                    case (w_step_adv)
                        3'd0, 3'd3: begin
                            w_ok = w_front;
                            if (w_front) w_move = rdps_pkg::MOVE_FWD;
                        end
                        3'd1, 3'd2: begin
                            w_ok = w_left;
                            if (w_left) w_move = rdps_pkg::MOVE_RIGHT;
                        end
                        3'd4, 3'd5: begin
                            w_ok = w_right;
                            if (w_right) w_move = rdps_pkg::MOVE_LEFT;
                        end
                        default: begin
                            w_ok = 1'b1;
                        end
                    endcase
                    // A failed guard also stops suction; steps past the table leave it.
                    if (w_step_adv <= 3'd5) n_suction = w_ok;
                end
                rdps_pkg::CMD_PATTERN_U: begin
                    if (w_due) n_step_start = i_item.now_ms;
                    n_step_index = w_step_adv;
                    case (w_step_adv)
                        3'd0, 3'd3: begin
                            w_move    = rdps_pkg::MOVE_FWD;
                            n_suction = 1'b1;
                        end
                        3'd1, 3'd2: begin
                            w_move    = rdps_pkg::MOVE_RIGHT;
                            n_suction = 1'b1;
                        end
                        3'd4, 3'd5: begin
                            w_move    = rdps_pkg::MOVE_LEFT;
                            n_suction = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                rdps_pkg::CMD_PATTERN_K: begin
                    if (w_due) n_step_start = i_item.now_ms;
                    n_step_index = w_step_adv;
                    if (w_step_adv == 3'd0) begin
                        w_move = rdps_pkg::MOVE_FWD;
                    end else if (w_step_adv == 3'd2) begin
                        w_move = rdps_pkg::MOVE_BACK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Manoeuvre to motor directions and duties.
    always_comb begin
        o_result = '0;
        case (w_move)
            rdps_pkg::MOVE_FWD: begin
                o_result.motor_a_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_b_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_c_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_d_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_a_duty = i_cfg.straight_duty;
                o_result.motor_b_duty = i_cfg.straight_duty;
                o_result.motor_c_duty = i_cfg.straight_duty;
                o_result.motor_d_duty = i_cfg.straight_duty;
            end
            rdps_pkg::MOVE_BACK: begin
                o_result.motor_a_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_b_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_c_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_d_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_a_duty = i_cfg.straight_duty;
                o_result.motor_b_duty = i_cfg.straight_duty;
                o_result.motor_c_duty = i_cfg.straight_duty;
                o_result.motor_d_duty = i_cfg.straight_duty;
            end
            rdps_pkg::MOVE_RIGHT: begin
                o_result.motor_a_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_b_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_c_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_d_dir  = rdps_pkg::DIR_SECOND;
                o_result.motor_a_duty = i_cfg.turn_duty;
                o_result.motor_b_duty = i_cfg.turn_duty;
                o_result.motor_c_duty = i_cfg.turn_duty;
                o_result.motor_d_duty = i_cfg.turn_duty;
            end
            rdps_pkg::MOVE_LEFT: begin
                o_result.motor_a_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_b_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_c_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_d_dir  = rdps_pkg::DIR_FIRST;
                o_result.motor_a_duty = i_cfg.turn_duty;
                o_result.motor_b_duty = i_cfg.boost_duty;
                o_result.motor_c_duty = i_cfg.turn_duty;
                o_result.motor_d_duty = i_cfg.boost_duty;
            end
            default: begin
            end
        endcase
        o_result.suction_on   = n_suction;
        o_result.pattern_step = n_step_index;
    end

    // Sequencer state, updated once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_command <= rdps_pkg::CMD_NONE;
            r_step_index   <= '0;
            r_step_start   <= '0;
            r_suction      <= 1'b0;
        end else if (i_fire) begin
            r_held_command <= n_held_command;
            r_step_index   <= n_step_index;
            r_step_start   <= n_step_start;
            r_suction      <= n_suction;
        end
    end

    // A manual item clears the step and keeps suction as it was.
    a_manual_clears_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.manual_switch |=> r_step_index == '0)
        else $error("manual item did not clear the pattern step");

    a_manual_keeps_suction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.manual_switch |=> r_suction == $past(r_suction))
        else $error("manual item changed the suction latch");

    // The step never leaves the range of the longest pattern.
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rdps_pkg::t_step_ext'(r_step_index) < rdps_pkg::PATTERN_LIMIT)
        else $error("pattern step out of range");

    // Manual mode always stops every wheel.
    a_manual_stops_wheels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.manual_switch |->
            o_result.motor_a_dir == rdps_pkg::DIR_OFF
            && o_result.motor_b_dir == rdps_pkg::DIR_OFF
            && o_result.motor_c_dir == rdps_pkg::DIR_OFF
            && o_result.motor_d_dir == rdps_pkg::DIR_OFF)
        else $error("wheels driven in manual mode");

endmodule

// File: hdl/remote_drive_pattern_sequencer.sv
// Remote drive pattern sequencer: input register, decode core and result register.
// An accepted input item passes through the input register and then the result register to the outputs.
// Throughput: one item per cycle while the output is not stalled; the state update is a single pass of decode logic.
// A stalled result holds in the output register while one more item waits in the input stage.
// Reset (i_rst_n low, synchronous) empties both stages, clears the command, step, step time
// and suction latch, and loads the default configuration values.
module remote_drive_pattern_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rdps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [rdps_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [rdps_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rdps_pkg::SAMPLE_BITS-1:0]    i_front_sample,
    input  logic [rdps_pkg::SAMPLE_BITS-1:0]    i_left_sample,
    input  logic [rdps_pkg::SAMPLE_BITS-1:0]    i_right_sample,
    input  logic [rdps_pkg::SAMPLE_BITS-1:0]    i_rear_sample,
    input  logic                                i_manual_switch,
    input  logic                                i_byte_valid,
    input  logic [rdps_pkg::BYTE_BITS-1:0]      i_rx_byte,
    input  logic [rdps_pkg::TIME_BITS-1:0]      i_now_ms,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rdps_pkg::DIR_BITS-1:0]       o_motor_a_dir,
    output logic [rdps_pkg::DUTY_BITS-1:0]      o_motor_a_duty,
    output logic [rdps_pkg::DIR_BITS-1:0]       o_motor_b_dir,
    output logic [rdps_pkg::DUTY_BITS-1:0]      o_motor_b_duty,
    output logic [rdps_pkg::DIR_BITS-1:0]       o_motor_c_dir,
    output logic [rdps_pkg::DUTY_BITS-1:0]      o_motor_c_duty,
    output logic [rdps_pkg::DIR_BITS-1:0]       o_motor_d_dir,
    output logic [rdps_pkg::DUTY_BITS-1:0]      o_motor_d_duty,
    output logic                                o_suction_on,
    output logic [rdps_pkg::STEP_BITS-1:0]      o_pattern_step
);

    rdps_pkg::t_cfg     w_cfg;
    rdps_pkg::t_result  w_result;
    rdps_pkg::t_item    r_item;
    rdps_pkg::t_result  r_result;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               w_advance;
    logic               w_accept;
    logic               w_fire;

    rdps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rdps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Pipeline flow: the input stage moves on whenever the result register can take a value.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_fire     = r_in_valid && w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.front_sample  <= i_front_sample;
            r_item.left_sample   <= i_left_sample;
            r_item.right_sample  <= i_right_sample;
            r_item.rear_sample   <= i_rear_sample;
            r_item.manual_switch <= i_manual_switch;
            r_item.byte_valid    <= i_byte_valid;
            r_item.rx_byte       <= i_rx_byte;
            r_item.now_ms        <= i_now_ms;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motor_a_dir  = r_result.motor_a_dir;
    assign o_motor_a_duty = r_result.motor_a_duty;
    assign o_motor_b_dir  = r_result.motor_b_dir;
    assign o_motor_b_duty = r_result.motor_b_duty;
    assign o_motor_c_dir  = r_result.motor_c_dir;
    assign o_motor_c_duty = r_result.motor_c_duty;
    assign o_motor_d_dir  = r_result.motor_d_dir;
    assign o_motor_d_duty = r_result.motor_d_duty;
    assign o_suction_on   = r_result.suction_on;
    assign o_pattern_step = r_result.pattern_step;

endmodule

// File: tb/tb_remote_drive_pattern_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for remote_drive_pattern_sequencer: drives floor samples, commands
// and time stamps, predicts the wheel, suction and step outputs and compares every result item.
// Depends on rdps_pkg and the remote_drive_pattern_sequencer RTL only.
module tb_remote_drive_pattern_sequencer;

    localparam int CLK_HALF_NS   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_LIMIT    = 1000;
    localparam int LONG_HOLD     = 80;
    localparam int MAX_GAP       = 11;
    localparam int SETTLE_CYCLES = 4;

    // Drive sequencer predictor: mirrors the registers and state, and queues expected results.
    class drive_scoreboard;
        logic [rdps_pkg::THRESH_BITS-1:0] thr;
        logic [rdps_pkg::PERIOD_BITS-1:0] pat_per;
        logic [rdps_pkg::PERIOD_BITS-1:0] shut_per;
        logic [rdps_pkg::DUTY_BITS-1:0]   str_duty;
        logic [rdps_pkg::DUTY_BITS-1:0]   trn_duty;
        logic [rdps_pkg::DUTY_BITS-1:0]   bst_duty;
        logic [rdps_pkg::BYTE_BITS-1:0]   held_cmd;
        logic [rdps_pkg::STEP_BITS-1:0]   step;
        logic [rdps_pkg::TIME_BITS-1:0]   step_time;
        logic                             suction;
        rdps_pkg::t_result                expected_q[$];
        int                               errors;
        int                               noted;
        int                               checked;
        int                               advances;

        function new();
            thr       = rdps_pkg::RST_FLOOR_THRESHOLD;
            pat_per   = rdps_pkg::RST_PATTERN_PERIOD;
            shut_per  = rdps_pkg::RST_SHUTTLE_PERIOD;
            str_duty  = rdps_pkg::RST_STRAIGHT_DUTY;
            trn_duty  = rdps_pkg::RST_TURN_DUTY;
            bst_duty  = rdps_pkg::RST_BOOST_DUTY;
            held_cmd  = rdps_pkg::CMD_NONE;
            step      = '0;
            step_time = '0;
            suction   = 1'b0;
            errors    = 0;
            noted     = 0;
            checked   = 0;
            advances  = 0;
        endfunction

        function void set_reg(logic [rdps_pkg::REG_IDX_BITS-1:0] idx, logic [31:0] v);
            case (idx)
                rdps_pkg::REG_FLOOR_THRESHOLD: thr      = v[rdps_pkg::THRESH_BITS-1:0];
                rdps_pkg::REG_PATTERN_PERIOD:  pat_per  = v[rdps_pkg::PERIOD_BITS-1:0];
                rdps_pkg::REG_SHUTTLE_PERIOD:  shut_per = v[rdps_pkg::PERIOD_BITS-1:0];
                rdps_pkg::REG_STRAIGHT_DUTY:   str_duty = v[rdps_pkg::DUTY_BITS-1:0];
                rdps_pkg::REG_TURN_DUTY:       trn_duty = v[rdps_pkg::DUTY_BITS-1:0];
                rdps_pkg::REG_BOOST_DUTY:      bst_duty = v[rdps_pkg::DUTY_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [rdps_pkg::REG_IDX_BITS-1:0] idx);
            case (idx)
                rdps_pkg::REG_FLOOR_THRESHOLD: return 32'(thr);
                rdps_pkg::REG_PATTERN_PERIOD:  return 32'(pat_per);
                rdps_pkg::REG_SHUTTLE_PERIOD:  return 32'(shut_per);
                rdps_pkg::REG_STRAIGHT_DUTY:   return 32'(str_duty);
                rdps_pkg::REG_TURN_DUTY:       return 32'(trn_duty);
                rdps_pkg::REG_BOOST_DUTY:      return 32'(bst_duty);
                default:                       return 32'd0;
            endcase
        endfunction

        // Moves to the next step once the period has elapsed, with wrapping time arithmetic.
        function void bump_step(logic [rdps_pkg::TIME_BITS-1:0] now,
                                logic [rdps_pkg::PERIOD_BITS-1:0] per, int lim);
            logic [rdps_pkg::TIME_BITS-1:0] elapsed;
            int                             n;
            elapsed = now - step_time;
            if (elapsed >= 32'(per)) begin
                step_time = now;
                n = int'(step) + 1;
                if (n >= lim) n = 0;
                step = n[rdps_pkg::STEP_BITS-1:0];
                advances++;
            end
        endfunction

        // Wheel directions and duties for one manoeuvre.
        function rdps_pkg::t_result wheels(logic [rdps_pkg::MOVE_BITS-1:0] mv);
            rdps_pkg::t_result r;
            r = '0;
            case (mv)
                rdps_pkg::MOVE_FWD: begin
                    r.motor_a_dir = rdps_pkg::DIR_SECOND; r.motor_b_dir = rdps_pkg::DIR_FIRST;
                    r.motor_c_dir = rdps_pkg::DIR_SECOND; r.motor_d_dir = rdps_pkg::DIR_FIRST;
                    r.motor_a_duty = str_duty; r.motor_b_duty = str_duty;
                    r.motor_c_duty = str_duty; r.motor_d_duty = str_duty;
                end
                rdps_pkg::MOVE_BACK: begin
                    r.motor_a_dir = rdps_pkg::DIR_FIRST; r.motor_b_dir = rdps_pkg::DIR_SECOND;
                    r.motor_c_dir = rdps_pkg::DIR_FIRST; r.motor_d_dir = rdps_pkg::DIR_SECOND;
                    r.motor_a_duty = str_duty; r.motor_b_duty = str_duty;
                    r.motor_c_duty = str_duty; r.motor_d_duty = str_duty;
                end
                rdps_pkg::MOVE_RIGHT: begin
                    r.motor_a_dir = rdps_pkg::DIR_SECOND; r.motor_b_dir = rdps_pkg::DIR_SECOND;
                    r.motor_c_dir = rdps_pkg::DIR_SECOND; r.motor_d_dir = rdps_pkg::DIR_SECOND;
                    r.motor_a_duty = trn_duty; r.motor_b_duty = trn_duty;
                    r.motor_c_duty = trn_duty; r.motor_d_duty = trn_duty;
                end
                rdps_pkg::MOVE_LEFT: begin
                    r.motor_a_dir = rdps_pkg::DIR_FIRST; r.motor_b_dir = rdps_pkg::DIR_FIRST;
                    r.motor_c_dir = rdps_pkg::DIR_FIRST; r.motor_d_dir = rdps_pkg::DIR_FIRST;
                    r.motor_a_duty = trn_duty; r.motor_b_duty = bst_duty;
                    r.motor_c_duty = trn_duty; r.motor_d_duty = bst_duty;
                end
                default: ;
            endcase
            return r;
        endfunction

        // Updates the state for one accepted item and queues the result it must produce.
        function void note_input(rdps_pkg::t_item it);
            rdps_pkg::t_result              r;
            logic                           fp;
            logic                           lp;
            logic                           rp;
            logic                           bp;
            logic                           ok;
            logic [rdps_pkg::MOVE_BITS-1:0] mv;
            fp = it.front_sample < thr;
            lp = it.left_sample < thr;
            rp = it.right_sample < thr;
            bp = it.rear_sample < thr;
            mv = rdps_pkg::MOVE_STOP;
            noted++;
            if (it.manual_switch) begin
                step      = '0;
                step_time = it.now_ms;
            end else begin
                if (it.byte_valid) held_cmd = it.rx_byte;
                case (held_cmd)
                    rdps_pkg::CMD_FWD_GUARD:  if (fp) mv = rdps_pkg::MOVE_FWD;
                    rdps_pkg::CMD_FWD:        mv = rdps_pkg::MOVE_FWD;
                    rdps_pkg::CMD_BACK_GUARD: if (bp) mv = rdps_pkg::MOVE_BACK;
                    rdps_pkg::CMD_BACK:       mv = rdps_pkg::MOVE_BACK;
                    rdps_pkg::CMD_RIGHT:      mv = rdps_pkg::MOVE_RIGHT;
                    rdps_pkg::CMD_LEFT:       mv = rdps_pkg::MOVE_LEFT;
                    rdps_pkg::CMD_STOP, rdps_pkg::CMD_SUCK_OFF: suction = 1'b0;
                    rdps_pkg::CMD_SUCK_ON:    suction = 1'b1;
                    rdps_pkg::CMD_PATTERN_I: begin
                        bump_step(it.now_ms, pat_per, rdps_pkg::PATTERN_STEPS);
                        ok = 1'b1;
                        case (step)
                            3'd0, 3'd3: begin ok = fp; if (ok) mv = rdps_pkg::MOVE_FWD;   end
                            3'd1, 3'd2: begin ok = lp; if (ok) mv = rdps_pkg::MOVE_RIGHT; end
                            3'd4, 3'd5: begin ok = rp; if (ok) mv = rdps_pkg::MOVE_LEFT;  end
                            default: ;
                        endcase
                        if (step <= 3'd5) suction = ok;
                    end
                    rdps_pkg::CMD_PATTERN_U: begin
                        bump_step(it.now_ms, pat_per, rdps_pkg::PATTERN_STEPS);
                        case (step)
                            3'd0, 3'd3: begin mv = rdps_pkg::MOVE_FWD;   suction = 1'b1; end
                            3'd1, 3'd2: begin mv = rdps_pkg::MOVE_RIGHT; suction = 1'b1; end
                            3'd4, 3'd5: begin mv = rdps_pkg::MOVE_LEFT;  suction = 1'b1; end
                            default: ;
                        endcase
                    end
                    rdps_pkg::CMD_PATTERN_K: begin
                        bump_step(it.now_ms, shut_per, rdps_pkg::SHUTTLE_STEPS);
                        if (step == 3'd0) mv = rdps_pkg::MOVE_FWD;
                        else if (step == 3'd2) mv = rdps_pkg::MOVE_BACK;
                    end
                    default: ;
                endcase
            end
            r = wheels(mv);
            r.suction_on   = suction;
            r.pattern_step = step;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned e, int unsigned g);
            if (e != g) begin
                $error("%s: expected %0d, got %0d", name, e, g);
                errors++;
            end
        endfunction

        function void check_result(rdps_pkg::t_result got);
            rdps_pkg::t_result e;
            if (expected_q.size() == 0) begin
                $error("result item arrived with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare_field("motor_a_dir", e.motor_a_dir, got.motor_a_dir);
            compare_field("motor_a_duty", e.motor_a_duty, got.motor_a_duty);
            compare_field("motor_b_dir", e.motor_b_dir, got.motor_b_dir);
            compare_field("motor_b_duty", e.motor_b_duty, got.motor_b_duty);
            compare_field("motor_c_dir", e.motor_c_dir, got.motor_c_dir);
            compare_field("motor_c_duty", e.motor_c_duty, got.motor_c_duty);
            compare_field("motor_d_dir", e.motor_d_dir, got.motor_d_dir);
            compare_field("motor_d_duty", e.motor_d_duty, got.motor_d_duty);
            compare_field("suction_on", e.suction_on, got.suction_on);
            compare_field("pattern_step", e.pattern_step, got.pattern_step);
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [rdps_pkg::CFG_ADDR_BITS-1:0]   paddr = '0;
    logic [rdps_pkg::CFG_DATA_BITS-1:0]   pwdata = '0;
    logic [rdps_pkg::CFG_DATA_BITS-1:0]   prdata;
    logic                                 pready;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [rdps_pkg::SAMPLE_BITS-1:0]     i_front_sample = '0;
    logic [rdps_pkg::SAMPLE_BITS-1:0]     i_left_sample = '0;
    logic [rdps_pkg::SAMPLE_BITS-1:0]     i_right_sample = '0;
    logic [rdps_pkg::SAMPLE_BITS-1:0]     i_rear_sample = '0;
    logic                                 i_manual_switch = 1'b0;
    logic                                 i_byte_valid = 1'b0;
    logic [rdps_pkg::BYTE_BITS-1:0]       i_rx_byte = '0;
    logic [rdps_pkg::TIME_BITS-1:0]       i_now_ms = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b1;
    logic [rdps_pkg::DIR_BITS-1:0]        o_motor_a_dir;
    logic [rdps_pkg::DUTY_BITS-1:0]       o_motor_a_duty;
    logic [rdps_pkg::DIR_BITS-1:0]        o_motor_b_dir;
    logic [rdps_pkg::DUTY_BITS-1:0]       o_motor_b_duty;
    logic [rdps_pkg::DIR_BITS-1:0]        o_motor_c_dir;
    logic [rdps_pkg::DUTY_BITS-1:0]       o_motor_c_duty;
    logic [rdps_pkg::DIR_BITS-1:0]        o_motor_d_dir;
    logic [rdps_pkg::DUTY_BITS-1:0]       o_motor_d_duty;
    logic                                 o_suction_on;
    logic [rdps_pkg::STEP_BITS-1:0]       o_pattern_step;

    drive_scoreboard                sb = new();
    bit                             rx_hold_req = 1'b0;
    logic [rdps_pkg::TIME_BITS-1:0] clock_ms = '0;
    int                             settings_used = 1;

    remote_drive_pattern_sequencer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_front_sample (i_front_sample),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_rear_sample  (i_rear_sample),
        .i_manual_switch(i_manual_switch),
        .i_byte_valid   (i_byte_valid),
        .i_rx_byte      (i_rx_byte),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_motor_a_dir  (o_motor_a_dir),
        .o_motor_a_duty (o_motor_a_duty),
        .o_motor_b_dir  (o_motor_b_dir),
        .o_motor_b_duty (o_motor_b_duty),
        .o_motor_c_dir  (o_motor_c_dir),
        .o_motor_c_duty (o_motor_c_duty),
        .o_motor_d_dir  (o_motor_d_dir),
        .o_motor_d_duty (o_motor_d_duty),
        .o_suction_on   (o_suction_on),
        .o_pattern_step (o_pattern_step)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    function automatic rdps_pkg::t_item mk(logic [rdps_pkg::SAMPLE_BITS-1:0] fs,
                                           logic [rdps_pkg::SAMPLE_BITS-1:0] ls,
                                           logic [rdps_pkg::SAMPLE_BITS-1:0] rs,
                                           logic [rdps_pkg::SAMPLE_BITS-1:0] bs,
                                           logic man, logic bv,
                                           logic [rdps_pkg::BYTE_BITS-1:0] rx,
                                           logic [rdps_pkg::TIME_BITS-1:0] now);
        rdps_pkg::t_item it;
        it.front_sample  = fs;
        it.left_sample   = ls;
        it.right_sample  = rs;
        it.rear_sample   = bs;
        it.manual_switch = man;
        it.byte_valid    = bv;
        it.rx_byte       = rx;
        it.now_ms        = now;
        return it;
    endfunction

    // Offers one item after a gap and waits until the block takes it.
    task automatic send_item(input rdps_pkg::t_item it, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_front_sample  <= it.front_sample;
        i_left_sample   <= it.left_sample;
        i_right_sample  <= it.right_sample;
        i_rear_sample   <= it.rear_sample;
        i_manual_switch <= it.manual_switch;
        i_byte_valid    <= it.byte_valid;
        i_rx_byte       <= it.rx_byte;
        i_now_ms        <= it.now_ms;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(it);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register, then reads it back.
    task automatic write_reg(input logic [rdps_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, val);
        want = sb.reg_value(idx);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Loads one register setting: low extremes, high extremes, fast patterns or anything.
    task automatic load_setting(input int which);
        logic [31:0] th;
        logic [31:0] pp;
        logic [31:0] sp;
        logic [31:0] d0;
        logic [31:0] d1;
        logic [31:0] d2;
        case (which)
            0: begin th = 0; pp = 0; sp = 0; d0 = 0; d1 = 0; d2 = 0; end
            1: begin th = 1023; pp = 65535; sp = 65535; d0 = 255; d1 = 255; d2 = 255; end
            2: begin
                th = $urandom_range(1, 1022);
                pp = $urandom_range(1, 40);
                sp = $urandom_range(1, 40);
                d0 = $urandom_range(0, 255);
                d1 = $urandom_range(0, 255);
                d2 = $urandom_range(0, 255);
            end
            default: begin
                th = $urandom_range(0, 1023);
                pp = $urandom_range(0, 65535);
                sp = $urandom_range(0, 65535);
                d0 = $urandom_range(0, 255);
                d1 = $urandom_range(0, 255);
                d2 = $urandom_range(0, 255);
            end
        endcase
        write_reg(rdps_pkg::REG_FLOOR_THRESHOLD, th);
        write_reg(rdps_pkg::REG_PATTERN_PERIOD, pp);
        write_reg(rdps_pkg::REG_SHUTTLE_PERIOD, sp);
        write_reg(rdps_pkg::REG_STRAIGHT_DUTY, d0);
        write_reg(rdps_pkg::REG_TURN_DUTY, d1);
        write_reg(rdps_pkg::REG_BOOST_DUTY, d2);
        settings_used++;
    endtask

    // Samples land mostly on either side of the threshold, sometimes anywhere.
    function automatic logic [rdps_pkg::SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return rdps_pkg::SAMPLE_BITS'($urandom_range(0, 1023));
        if (r < 6 && sb.thr != 0) return rdps_pkg::SAMPLE_BITS'($urandom_range(0, sb.thr - 1));
        return rdps_pkg::SAMPLE_BITS'($urandom_range(sb.thr, 1023));
    endfunction

    // Time mostly advances by about a period; some items land right on the step boundary.
    function automatic logic [rdps_pkg::TIME_BITS-1:0] next_time();
        logic [31:0] per;
        int          pick;
        per  = (sb.held_cmd == rdps_pkg::CMD_PATTERN_K) ? 32'(sb.shut_per) : 32'(sb.pat_per);
        pick = $urandom_range(0, 99);
        if (pick < 3) clock_ms = $urandom;
        else if (pick < 18) clock_ms = sb.step_time + per - $urandom_range(0, 1);
        else clock_ms = clock_ms + $urandom_range(0, per + per / 2 + 1);
        return clock_ms;
    endfunction

    // Patterns are drawn more often than single moves since they reach the most state.
    function automatic logic [rdps_pkg::BYTE_BITS-1:0] pick_command();
        case ($urandom_range(0, 17))
            0:  return rdps_pkg::CMD_FWD_GUARD;
            1:  return rdps_pkg::CMD_FWD;
            2:  return rdps_pkg::CMD_BACK_GUARD;
            3:  return rdps_pkg::CMD_BACK;
            4:  return rdps_pkg::CMD_RIGHT;
            5:  return rdps_pkg::CMD_LEFT;
            6:  return rdps_pkg::CMD_STOP;
            7:  return rdps_pkg::CMD_SUCK_ON;
            8:  return rdps_pkg::CMD_SUCK_OFF;
            9, 12, 13:  return rdps_pkg::CMD_PATTERN_I;
            10, 14, 15: return rdps_pkg::CMD_PATTERN_U;
            default:    return rdps_pkg::CMD_PATTERN_K;
        endcase
    endfunction

    // One item of a command session: the command first, then mostly plain ticks with some noise.
    function automatic rdps_pkg::t_item session_item(bit first,
                                                     logic [rdps_pkg::BYTE_BITS-1:0] cmd);
        rdps_pkg::t_item it;
        int              r;
        r = $urandom_range(0, 99);
        it.front_sample  = pick_sample();
        it.left_sample   = pick_sample();
        it.right_sample  = pick_sample();
        it.rear_sample   = pick_sample();
        it.manual_switch = !first && r < 5;
        it.byte_valid    = 1'b0;
        it.rx_byte       = rdps_pkg::BYTE_BITS'($urandom_range(0, 255));
        if (first) begin
            it.byte_valid = 1'b1;
            it.rx_byte    = cmd;
        end else if (r < 12) begin
            it.byte_valid = 1'b1;
        end else if (r < 17) begin
            it.byte_valid = 1'b1;
            it.rx_byte    = cmd;
        end
        it.now_ms = next_time();
        return it;
    endfunction

    task automatic run_sessions(input int count);
        int                             sent;
        int                             k;
        int                             len;
        bit                             burst;
        logic [rdps_pkg::BYTE_BITS-1:0] cmd;
        sent = 0;
        while (sent < count) begin
            cmd   = pick_command();
            len   = $urandom_range(4, 30);
            burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len && sent < count; k++) begin
                send_item(session_item(k == 0, cmd), burst ? 0 : $urandom_range(0, MAX_GAP));
                sent++;
            end
        end
    endtask

    // Starts a phase at a random time, half of the time just short of the wrap of the counter.
    task automatic start_clock();
        if ($urandom_range(0, 1) != 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        else clock_ms = $urandom;
    endtask

    // Result side: random stalls per item, calm stretches, and one long hold on request.
    initial begin
        int                wait_cycles;
        int                taken;
        bit                fast;
        rdps_pkg::t_result got;
        taken = 0;
        fast  = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                wait_cycles = LONG_HOLD;
            end else if (fast) begin
                wait_cycles = 0;
            end else begin
                wait_cycles = $urandom_range(0, MAX_GAP);
            end
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.motor_a_dir  = o_motor_a_dir;
            got.motor_a_duty = o_motor_a_duty;
            got.motor_b_dir  = o_motor_b_dir;
            got.motor_b_duty = o_motor_b_duty;
            got.motor_c_dir  = o_motor_c_dir;
            got.motor_c_duty = o_motor_c_duty;
            got.motor_d_dir  = o_motor_d_dir;
            got.motor_d_duty = o_motor_d_duty;
            got.suction_on   = o_suction_on;
            got.pattern_step = o_pattern_step;
            sb.check_result(got);
            taken++;
            if (taken % 40 == 0) fast = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                idle = 0;
            else
                idle++;
        end
        $display("remote_drive_pattern_sequencer verification failed");
        $finish;
    end

    // Main sequence: reset, directed cases, then random sessions under several settings.
    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases under the reset configuration (threshold 300, periods 2000 and 3000).
        // Nothing held yet, then a byte in manual mode which must not be latched.
        send_item(mk(0, 0, 0, 0, 0, 0, rdps_pkg::CMD_FWD, 0), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 1, 1, rdps_pkg::CMD_FWD, 10), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 1023, 1023, 1023, 0, 0, rdps_pkg::CMD_FWD, 20),
                  $urandom_range(0, MAX_GAP));
        // Guarded moves on both sides of the threshold, then the unguarded ones.
        send_item(mk(299, 0, 0, 0, 0, 1, rdps_pkg::CMD_FWD_GUARD, 30),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(300, 0, 0, 0, 0, 0, 8'hAA, 40), $urandom_range(0, MAX_GAP));
        send_item(mk(1023, 0, 0, 0, 0, 1, rdps_pkg::CMD_FWD, 50), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 299, 0, 1, rdps_pkg::CMD_BACK_GUARD, 60),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 1023, 0, 0, 8'h55, 70), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 1023, 0, 1, rdps_pkg::CMD_BACK, 80), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_RIGHT, 90), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_LEFT, 100), $urandom_range(0, MAX_GAP));
        // Suction control; manual mode and an unknown byte leave it alone.
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_SUCK_ON, 110), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 1, 0, rdps_pkg::CMD_NONE, 130), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 1, 8'hFF, 140), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_SUCK_OFF, 150),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_SUCK_ON, 160), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_STOP, 170), $urandom_range(0, MAX_GAP));
        // Guarded pattern: hold, advance on the exact period, then a failed guard.
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_PATTERN_I, 200),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(1023, 0, 0, 0, 0, 0, rdps_pkg::CMD_NONE, 2130),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(0, 1023, 0, 0, 0, 0, rdps_pkg::CMD_NONE, 4130),
                  $urandom_range(0, MAX_GAP));
        // Manual restarts the step; unguarded pattern just short of and past its period.
        send_item(mk(0, 0, 0, 0, 1, 0, rdps_pkg::CMD_NONE, 5000), $urandom_range(0, MAX_GAP));
        send_item(mk(1023, 1023, 1023, 1023, 0, 1, rdps_pkg::CMD_PATTERN_U, 6999),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(1023, 1023, 1023, 1023, 0, 0, rdps_pkg::CMD_NONE, 9000),
                  $urandom_range(0, MAX_GAP));
        // Shuttle: the pause step, then backward, then the wrap to forward.
        send_item(mk(0, 0, 0, 0, 0, 1, rdps_pkg::CMD_PATTERN_K, 11999),
                  $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 0, rdps_pkg::CMD_NONE, 12000), $urandom_range(0, MAX_GAP));
        send_item(mk(0, 0, 0, 0, 0, 0, rdps_pkg::CMD_NONE, 15000), $urandom_range(0, MAX_GAP));
        drain();

        // Back-pressure: the result side holds off while items keep coming back to back.
        start_clock();
        rx_hold_req = 1'b1;
        send_item(session_item(1'b1, rdps_pkg::CMD_PATTERN_U), 0);
        for (k = 1; k < 24; k++) send_item(session_item(1'b0, rdps_pkg::CMD_PATTERN_U), 0);
        drain();
        run_sessions(150);
        drain();

        // Remaining settings: low extremes, high extremes, fast patterns, anything.
        for (k = 0; k < 4; k++) begin
            load_setting(k);
            start_clock();
            run_sessions(160);
            drain();
        end

        $display("Summary: %0d items under %0d register settings, %0d results compared.",
                 sb.noted, settings_used, sb.checked);
        $display("Pattern steps advanced %0d times; long output hold and full drains included.",
                 sb.advances);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("remote_drive_pattern_sequencer verification clean");
        else
            $display("remote_drive_pattern_sequencer verification failed");
        $finish;
    end

endmodule
